@@ sv/rpc_hp_pkg.sv @@
// Shared types and constants for the RPC header parser.
package rpc_hp_pkg;

	localparam int MAX_MESSAGE_BYTES = 65536;
	localparam int MAX_WORDS         = MAX_MESSAGE_BYTES / 4;
	localparam int WC_W              = $clog2(MAX_WORDS + 2);
	localparam int LEN_W             = 17;
	localparam int AUTH_W            = 10;
	localparam int SKIP_W            = 8;

	localparam logic [AUTH_W-1:0] MAX_AUTH_RESET = AUTH_W'(400);
	localparam logic [WC_W-1:0]   MAX_WORDS_C    = WC_W'(MAX_WORDS);

	localparam logic [31:0] MSG_CALL          = 32'd0;
	localparam logic [31:0] MSG_REPLY         = 32'd1;
	localparam logic [31:0] RPC_VERSION       = 32'd2;
	localparam logic [31:0] REPLY_ACCEPTED    = 32'd0;
	localparam logic [31:0] REPLY_DENIED      = 32'd1;
	localparam logic [31:0] ACC_SUCCESS       = 32'd0;
	localparam logic [31:0] ACC_PROG_MISMATCH = 32'd2;
	localparam logic [31:0] ACC_LAST          = 32'd5;
	localparam logic [31:0] REJ_RPC_MISMATCH  = 32'd0;
	localparam logic [31:0] REJ_AUTH_ERROR    = 32'd1;

	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_PROG_MISMATCH = 4'd2;
	localparam logic [3:0] ST_RPC_MISMATCH  = 4'd6;
	localparam logic [3:0] ST_AUTH_ERROR    = 4'd7;
	localparam logic [3:0] ST_MALFORMED     = 4'd8;

	typedef enum logic [4:0] {
		PH_XID, PH_MTYPE, PH_RPCVERS, PH_PROG, PH_VERS, PH_PROC,
		PH_CFLAV, PH_CLEN, PH_CSKIP, PH_VFLAV, PH_VLEN, PH_VSKIP, PH_CALL_BODY,
		PH_RSTAT, PH_RVFLAV, PH_RVLEN, PH_RVSKIP, PH_ASTAT, PH_PM_LOW, PH_PM_HIGH,
		PH_DONE, PH_JSTAT, PH_AUTHCODE, PH_RM_LOW, PH_RM_HIGH, PH_SUCC_BODY
	} rpc_phase_t;

	typedef struct packed {
		logic              is_call;
		logic [31:0]       xid;
		logic [31:0]       program_res;
		logic [31:0]       prog_version;
		logic [31:0]       procedure;
		logic [3:0]        status;
		logic [31:0]       low_value;
		logic [31:0]       high_value;
		logic [31:0]       cred_flavor;
		logic [31:0]       verf_flavor;
		logic [LEN_W-1:0]  payload_offset;
		logic [LEN_W-1:0]  payload_length;
	} rpc_res_t;

endpackage

@@ sv/rpc_hp_if.sv @@
// Input word channel and summary result channel.
interface rpc_hp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        last;

	modport source (output valid, output word, output last, input ready);
	modport sink (input valid, input word, input last, output ready);
endinterface

interface rpc_hp_out_if;
	logic        valid;
	logic        ready;
	logic        is_call;
	logic [31:0] xid;
	logic [31:0] program_res;
	logic [31:0] prog_version;
	logic [31:0] procedure;
	logic [3:0]  status;
	logic [31:0] low_value;
	logic [31:0] high_value;
	logic [31:0] cred_flavor;
	logic [31:0] verf_flavor;
	logic [16:0] payload_offset;
	logic [16:0] payload_length;

	modport source (
		output valid, input ready,
		output is_call, output xid, output program_res, output prog_version,
		output procedure, output status, output low_value, output high_value,
		output cred_flavor, output verf_flavor, output payload_offset,
		output payload_length
	);
	modport sink (
		input valid, output ready,
		input is_call, input xid, input program_res, input prog_version,
		input procedure, input status, input low_value, input high_value,
		input cred_flavor, input verf_flavor, input payload_offset,
		input payload_length
	);
endinterface

@@ sv/rpc_hp_parse.sv @@
// Header walk: phase state, field capture and summary on the final word.
module rpc_hp_parse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rpc_hp_pkg::AUTH_W-1:0]  cfg_wdata,
	input  logic                           accept,
	input  logic [31:0]                    word,
	input  logic                           last,
	output logic                           res_valid,
	output rpc_hp_pkg::rpc_res_t           res
);
	import rpc_hp_pkg::*;

	logic [AUTH_W-1:0] max_auth_q;
	rpc_phase_t        ph_q, ph_d;
	logic [SKIP_W-1:0] skip_q, skip_d;
	logic [WC_W-1:0]   wc_q, wc_n, hw_q, hw_d;
	logic              mal_q, mal_d, call_q, call_d;
	logic [31:0]       xid_q, xid_d, prog_q, prog_d, vers_q, vers_d, proc_q, proc_d;
	logic [31:0]       low_q, low_d, high_q, high_d, cflav_q, cflav_d, vflav_q, vflav_d;
	logic [3:0]        stat_q, stat_d;
	logic              adv, len_bad, complete, too_long;
	logic [SKIP_W:0]   skip_full;
	logic [SKIP_W-1:0] skip_dec;
	logic [WC_W-1:0]   body_words;

	assign wc_n      = (wc_q <= MAX_WORDS_C) ? wc_q + 1'b1 : wc_q;
	assign adv       = !mal_q && (wc_n <= MAX_WORDS_C);
	assign len_bad   = word > {{(32-AUTH_W){1'b0}}, max_auth_q};
	assign skip_full = (SKIP_W+1)'(({1'b0, word[AUTH_W-1:0]} + (AUTH_W+1)'(3)) >> 2);
	assign skip_dec  = skip_q - 1'b1;

	always_comb begin
		ph_d    = ph_q;
		skip_d  = skip_q;
		mal_d   = mal_q;
		call_d  = call_q;
		xid_d   = xid_q;
		prog_d  = prog_q;
		vers_d  = vers_q;
		proc_d  = proc_q;
		low_d   = low_q;
		high_d  = high_q;
		cflav_d = cflav_q;
		vflav_d = vflav_q;
		stat_d  = stat_q;
		if (adv) begin
			case (ph_q)
				PH_XID: begin
					xid_d = word;
					ph_d  = PH_MTYPE;
				end
				PH_MTYPE: begin
					if (word == MSG_CALL) begin
						call_d = 1'b1;
						ph_d   = PH_RPCVERS;
					end else if (word == MSG_REPLY) ph_d = PH_RSTAT;
					else mal_d = 1'b1;
				end
				PH_RPCVERS: begin
					if (word == RPC_VERSION) ph_d = PH_PROG;
					else mal_d = 1'b1;
				end
				PH_PROG: begin
					prog_d = word;
					ph_d   = PH_VERS;
				end
				PH_VERS: begin
					vers_d = word;
					ph_d   = PH_PROC;
				end
				PH_PROC: begin
					proc_d = word;
					ph_d   = PH_CFLAV;
				end
				PH_CFLAV: begin
					cflav_d = word;
					ph_d    = PH_CLEN;
				end
				PH_CLEN, PH_VLEN, PH_RVLEN: begin
					if (len_bad) mal_d = 1'b1;
					else begin
						skip_d = skip_full[SKIP_W-1:0];
						case (ph_q)
							PH_CLEN: ph_d = (skip_full != '0) ? PH_CSKIP : PH_VFLAV;
							PH_VLEN: ph_d = (skip_full != '0) ? PH_VSKIP : PH_CALL_BODY;
							default: ph_d = (skip_full != '0) ? PH_RVSKIP : PH_ASTAT;
						endcase
					end
				end
				PH_CSKIP, PH_VSKIP, PH_RVSKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						case (ph_q)
							PH_CSKIP: ph_d = PH_VFLAV;
							PH_VSKIP: ph_d = PH_CALL_BODY;
							default:  ph_d = PH_ASTAT;
						endcase
					end
				end
				PH_VFLAV: begin
					vflav_d = word;
					ph_d    = PH_VLEN;
				end
				PH_RSTAT: begin
					if (word == REPLY_ACCEPTED) ph_d = PH_RVFLAV;
					else if (word == REPLY_DENIED) ph_d = PH_JSTAT;
					else mal_d = 1'b1;
				end
				PH_RVFLAV: begin
					vflav_d = word;
					ph_d    = PH_RVLEN;
				end
				PH_ASTAT: begin
					if (word == ACC_SUCCESS) begin
						stat_d = ST_OK;
						ph_d   = PH_SUCC_BODY;
					end else if (word == ACC_PROG_MISMATCH) begin
						stat_d = ST_PROG_MISMATCH;
						ph_d   = PH_PM_LOW;
					end else if (word <= ACC_LAST) begin
						stat_d = word[3:0];
						ph_d   = PH_DONE;
					end else mal_d = 1'b1;
				end
				PH_PM_LOW, PH_RM_LOW: begin
					low_d = word;
					ph_d  = (ph_q == PH_PM_LOW) ? PH_PM_HIGH : PH_RM_HIGH;
				end
				PH_PM_HIGH, PH_RM_HIGH: begin
					high_d = word;
					ph_d   = PH_DONE;
				end
				PH_JSTAT: begin
					if (word == REJ_AUTH_ERROR) begin
						stat_d = ST_AUTH_ERROR;
						ph_d   = PH_AUTHCODE;
					end else if (word == REJ_RPC_MISMATCH) begin
						stat_d = ST_RPC_MISMATCH;
						ph_d   = PH_RM_LOW;
					end else mal_d = 1'b1;
				end
				PH_AUTHCODE: begin
					low_d = word;
					ph_d  = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	assign complete = (ph_d == PH_CALL_BODY) || (ph_d == PH_SUCC_BODY) || (ph_d == PH_DONE);
	assign hw_d     = (ph_d != ph_q && complete) ? wc_n : hw_q;
	assign too_long = wc_n > MAX_WORDS_C;
	assign body_words = wc_n - hw_d;

	always_comb begin
		res     = '0;
		res.xid = xid_d;
		if (mal_d || too_long || !complete) begin
			res.status         = ST_MALFORMED;
			res.payload_offset = too_long ? LEN_W'(MAX_MESSAGE_BYTES)
			                              : LEN_W'({wc_n, 2'b00});
		end else begin
			res.is_call        = call_d;
			res.program_res    = prog_d;
			res.prog_version   = vers_d;
			res.procedure      = proc_d;
			res.status         = stat_d;
			res.low_value      = low_d;
			res.high_value     = high_d;
			res.cred_flavor    = cflav_d;
			res.verf_flavor    = vflav_d;
			res.payload_offset = LEN_W'({hw_d, 2'b00});
			if (ph_d != PH_DONE) res.payload_length = LEN_W'({body_words, 2'b00});
		end
	end

	assign res_valid = accept && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_auth_q <= MAX_AUTH_RESET;
		end else if (cfg_we) begin
			max_auth_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_XID;
			skip_q  <= '0;
			wc_q    <= '0;
			hw_q    <= '0;
			mal_q   <= 1'b0;
			call_q  <= 1'b0;
			xid_q   <= '0;
			prog_q  <= '0;
			vers_q  <= '0;
			proc_q  <= '0;
			low_q   <= '0;
			high_q  <= '0;
			cflav_q <= '0;
			vflav_q <= '0;
			stat_q  <= '0;
		end else if (accept) begin
			if (last) begin
				ph_q    <= PH_XID;
				skip_q  <= '0;
				wc_q    <= '0;
				hw_q    <= '0;
				mal_q   <= 1'b0;
				call_q  <= 1'b0;
				xid_q   <= '0;
				prog_q  <= '0;
				vers_q  <= '0;
				proc_q  <= '0;
				low_q   <= '0;
				high_q  <= '0;
				cflav_q <= '0;
				vflav_q <= '0;
				stat_q  <= '0;
			end else begin
				ph_q    <= ph_d;
				skip_q  <= skip_d;
				wc_q    <= wc_n;
				hw_q    <= hw_d;
				mal_q   <= mal_d;
				call_q  <= call_d;
				xid_q   <= xid_d;
				prog_q  <= prog_d;
				vers_q  <= vers_d;
				proc_q  <= proc_d;
				low_q   <= low_d;
				high_q  <= high_d;
				cflav_q <= cflav_d;
				vflav_q <= vflav_d;
				stat_q  <= stat_d;
			end
		end
	end

endmodule

@@ sv/rpc_hp_result.sv @@
// Result register holding one summary item until the sink takes it.
module rpc_hp_result (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  rpc_hp_pkg::rpc_res_t  res,
	output logic                  slot_free,
	rpc_hp_out_if.source          out
);
	import rpc_hp_pkg::*;

	logic     valid_q;
	rpc_res_t res_q;

	assign slot_free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out.valid          = valid_q;
	assign out.is_call        = res_q.is_call;
	assign out.xid            = res_q.xid;
	assign out.program_res    = res_q.program_res;
	assign out.prog_version   = res_q.prog_version;
	assign out.procedure      = res_q.procedure;
	assign out.status         = res_q.status;
	assign out.low_value      = res_q.low_value;
	assign out.high_value     = res_q.high_value;
	assign out.cred_flavor    = res_q.cred_flavor;
	assign out.verf_flavor    = res_q.verf_flavor;
	assign out.payload_offset = res_q.payload_offset;
	assign out.payload_length = res_q.payload_length;

endmodule

@@ sv/rpc_header_parser.sv @@
// The summary item is registered and appears in the cycle after the final word is accepted.
// Throughput: one word per cycle while in.ready is high; the phase update and field capture are combinational.
// A final word waits only while an earlier summary sits unread in the result register.
// Reset: arst_n clears the parse state and the result valid flag; the auth length limit max_auth_q returns to 400.
// Top level of the ONC RPC message header parser.
module rpc_header_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rpc_hp_pkg::AUTH_W-1:0]  cfg_wdata,
	rpc_hp_in_if.sink                      in,
	rpc_hp_out_if.source                   out
);
	import rpc_hp_pkg::*;

	logic     accept, res_valid, slot_free;
	rpc_res_t res;

	assign in.ready = !in.last || slot_free;
	assign accept   = in.valid && in.ready;

	rpc_hp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.word      (in.word),
		.last      (in.last),
		.res_valid (res_valid),
		.res       (res)
	);

	rpc_hp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out       (out)
	);

endmodule

@@ sv/rpc_hp_checker.sv @@
// Port-level checks for the RPC header parser, bound to the top level.
module rpc_hp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_is_call,
	input logic [3:0]  out_status,
	input logic [31:0] out_xid,
	input logic [16:0] out_payload_length
);
	import rpc_hp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_xid) && $stable(out_status))
		else $error("result changed while stalled");

	a_last_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("final word produced no result");

	a_item_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last))
		else $error("result without a final word");

	a_malformed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_MALFORMED |-> !out_is_call && out_payload_length == '0)
		else $error("malformed result carries call or payload data");

endmodule

bind rpc_header_parser rpc_hp_checker u_rpc_hp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in.valid),
	.in_ready           (in.ready),
	.in_last            (in.last),
	.out_valid          (out.valid),
	.out_ready          (out.ready),
	.out_is_call        (out.is_call),
	.out_status         (out.status),
	.out_xid            (out.xid),
	.out_payload_length (out.payload_length)
);
